// ===== design/at_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// at_rx_pkg: shared types and constants of the AT response receive scanner
// Holds the sizes, the command and register codes, and the structs that
// travel between the configuration file, the two tracking paths and the top.
// ----------------------------------------------------------------------------
package at_rx_pkg;

    localparam int BUF_LEN       = 128;
    localparam int NUM_PATTERNS  = 4;
    localparam int PATTERN_CHARS = 8;

    localparam int ADDR_W = 7;   // buffer address width
    localparam int SEL_W  = 2;   // pattern selector width
    localparam int POS_W  = 3;   // character position width
    localparam int CFG_W  = 64;  // configuration data width

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_U       = 8'h55;
    localparam logic [7:0] CHAR_R       = 8'h52;
    localparam logic [7:0] CHAR_C       = 8'h43;

    typedef enum logic [1:0] {
        MODE_CHAR      = 2'd0,
        MODE_CLR_RESP  = 2'd1,
        MODE_CLR_EVENT = 2'd2,
        MODE_NONE      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_PRINT_LOW  = 3'd0,
        CFG_PRINT_HIGH = 3'd1,
        CFG_BUF_LEN    = 3'd2,
        CFG_PATTERN_0  = 3'd3,
        CFG_PATTERN_1  = 3'd4,
        CFG_PATTERN_2  = 3'd5,
        CFG_PATTERN_3  = 3'd6,
        CFG_LAST_INDEX = 3'd7
    } t_cfg_idx;

    typedef logic [NUM_PATTERNS-1:0][PATTERN_CHARS-1:0][7:0] t_patterns;

    typedef struct packed {
        logic [7:0]                    print_low;
        logic [7:0]                    print_high;
        logic [7:0]                    resp_buffer_len;
        t_patterns                     patterns;
        logic [NUM_PATTERNS*POS_W-1:0] last_index;
    } t_cfg;

    // One decoded step, presented by the top to both tracking paths.
    typedef struct packed {
        logic       fire;       // step takes effect at this edge
        logic       chr;        // an accepted character
        logic       clr_resp;
        logic       clr_event;
        logic [7:0] c;
    } t_step;

    typedef struct packed {
        logic              resp_write;
        logic [ADDR_W-1:0] resp_addr;
        logic              resp_ready;
        logic              matched_now;
        logic [SEL_W-1:0]  matched_pattern;
    } t_resp_res;

    typedef struct packed {
        logic              event_write;
        logic [ADDR_W-1:0] event_addr;
        logic              event_line_done;
        logic              event_pending;
        logic [7:0]        event_count;
    } t_evt_res;

    function automatic logic [7:0] prefix_char(input logic [1:0] p);
        logic [7:0] ch;
        case (p)
            2'd0:    ch = CHAR_U;
            2'd1:    ch = CHAR_R;
            default: ch = CHAR_C;
        endcase
        return ch;
    endfunction

    function automatic logic [SEL_W-1:0] next_sel(input logic [SEL_W-1:0] s);
        logic [SEL_W-1:0] r;
        if (32'(s) >= NUM_PATTERNS - 1) begin
            r = '0;
        end else begin
            r = s + SEL_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== design/at_response_rx_scanner.sv =====
// ----------------------------------------------------------------------------
// at_response_rx_scanner: receive-side character scanner for a modem link
// Filters received characters, tracks unsolicited event lines and matches
// expected responses, emitting buffer write addresses for accepted characters.
// ----------------------------------------------------------------------------
// Usage:
// Command words arrive on the input channel (i_in_valid / o_in_stall) with a
// mode and a character. Every accepted word yields exactly one result word
// on the output channel (o_out_valid / i_out_stall). The caller holds the
// response and event buffers and writes o_char_out at the emitted addresses
// when o_resp_write or o_event_write is set.
// An accepted word is held in the input register; then the filter, the event
// path and the four-way pattern compare settle into the result register,
// which drives o_out_valid. A new word is taken every cycle while the
// receiver does not stall; the four-pattern priority compare sets the cycle
// time. When the receiver stalls, the held result stays put and the input
// register still takes one more word if it is empty; only then does
// o_in_stall rise.
// Configuration words (i_cfg_valid / o_cfg_ready) are always taken at once and
// must be written only while no word is in flight.
// Reset (i_rst_n low, synchronous) empties both registers, clears all
// scanner state and loads the register defaults: window 10..126, buffer
// length 128, patterns and final indexes zero.
// ----------------------------------------------------------------------------
module at_response_rx_scanner import at_rx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_rx_char,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [7:0]        o_char_out,
    output logic              o_resp_write,
    output logic [ADDR_W-1:0] o_resp_addr,
    output logic              o_resp_ready,
    output logic              o_matched_now,
    output logic [SEL_W-1:0]  o_matched_pattern,
    output logic              o_event_write,
    output logic [ADDR_W-1:0] o_event_addr,
    output logic              o_event_line_done,
    output logic              o_event_pending,
    output logic [7:0]        o_event_count
);

    t_cfg      cfg;
    t_step     step;
    t_resp_res resp_res;
    t_evt_res  evt_res;

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [7:0] r_rx_char;

    // Result register.
    logic       r_out_valid;
    logic       r_accepted;
    logic [7:0] r_char_out;
    t_resp_res  r_resp_res;
    t_evt_res   r_evt_res;

    logic advance;    // the result register can take a new word
    logic in_accept;
    logic in_window;

    at_rx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Decode the buffered word into one step for both paths.
    assign in_window = (r_rx_char >= cfg.print_low) && (r_rx_char <= cfg.print_high);

    always_comb begin
        step           = '0;
        step.fire      = r_in_valid && advance;
        step.c         = r_rx_char;
        unique case (t_mode'(r_mode))
            MODE_CHAR:      step.chr       = in_window;
            MODE_CLR_RESP:  step.clr_resp  = 1'b1;
            MODE_CLR_EVENT: step.clr_event = 1'b1;
            MODE_NONE:      ;
            default:        ;
        endcase
    end

    at_rx_event u_event (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_res   (evt_res)
    );

    at_rx_resp u_resp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .o_res   (resp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode    <= i_mode;
            r_rx_char <= i_rx_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.fire) begin
            r_accepted <= step.chr;
            r_char_out <= step.chr ? r_rx_char : 8'd0;
            r_resp_res <= resp_res;
            r_evt_res  <= evt_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_char_out        = r_char_out;
    assign o_resp_write      = r_resp_res.resp_write;
    assign o_resp_addr       = r_resp_res.resp_addr;
    assign o_resp_ready      = r_resp_res.resp_ready;
    assign o_matched_now     = r_resp_res.matched_now;
    assign o_matched_pattern = r_resp_res.matched_pattern;
    assign o_event_write     = r_evt_res.event_write;
    assign o_event_addr      = r_evt_res.event_addr;
    assign o_event_line_done = r_evt_res.event_line_done;
    assign o_event_pending   = r_evt_res.event_pending;
    assign o_event_count     = r_evt_res.event_count;

    // A completed match always leaves the response marked ready.
    a_match_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_matched_now |-> o_resp_ready)
        else $error("match reported without response ready");

    // A line end only comes from a captured character and sets the flag.
    a_line_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_line_done |-> o_event_write && o_event_pending)
        else $error("event line end without capture or flag");

    // Buffer writes happen only for characters inside the window.
    a_write_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_resp_write || o_event_write) |-> o_accepted)
        else $error("buffer write for a dropped character");

    // A processed word always shows up in the result register next cycle.
    a_step_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.fire |=> r_out_valid)
        else $error("processed word lost before the result register");

endmodule

// ===== design/at_rx_cfg.sv =====
// ----------------------------------------------------------------------------
// at_rx_cfg: configuration register file
// Holds the printable window, the response buffer length, the expected
// response patterns and their final character indexes.
// ----------------------------------------------------------------------------
module at_rx_cfg import at_rx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.print_low       <= 8'd10;
            r_cfg.print_high      <= 8'd126;
            r_cfg.resp_buffer_len <= 8'd128;
            r_cfg.patterns        <= '0;
            r_cfg.last_index      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRINT_LOW:  r_cfg.print_low       <= i_cfg_data[7:0];
                CFG_PRINT_HIGH: r_cfg.print_high      <= i_cfg_data[7:0];
                CFG_BUF_LEN:    r_cfg.resp_buffer_len <= i_cfg_data[7:0];
                CFG_PATTERN_0:  r_cfg.patterns[0] <= i_cfg_data[PATTERN_CHARS*8-1:0];
                CFG_PATTERN_1:  r_cfg.patterns[1] <= i_cfg_data[PATTERN_CHARS*8-1:0];
                CFG_PATTERN_2:  r_cfg.patterns[2] <= i_cfg_data[PATTERN_CHARS*8-1:0];
                CFG_PATTERN_3:  r_cfg.patterns[3] <= i_cfg_data[PATTERN_CHARS*8-1:0];
                CFG_LAST_INDEX: r_cfg.last_index <= i_cfg_data[NUM_PATTERNS*POS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/at_rx_event.sv =====
// ----------------------------------------------------------------------------
// at_rx_event: unsolicited event line tracker
// Watches for the prefix, steers the following characters to the event
// buffer until a newline, and keeps the sticky flag and the line count.
// ----------------------------------------------------------------------------
module at_rx_event import at_rx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_step    i_step,
    output t_evt_res o_res
);

    logic [1:0]        r_prefix_progress, n_prefix_progress;
    logic              r_capturing,       n_capturing;
    logic [ADDR_W-1:0] r_event_index,     n_event_index;
    logic              r_event_flag,      n_event_flag;
    logic [7:0]        r_event_lines,     n_event_lines;

    logic [1:0]        prog;
    logic [ADDR_W:0]   idx_inc;

    always_comb begin
        n_prefix_progress = r_prefix_progress;
        n_capturing       = r_capturing;
        n_event_index     = r_event_index;
        n_event_flag      = r_event_flag;
        n_event_lines     = r_event_lines;
        o_res             = '0;
        prog              = (r_prefix_progress > 2'd2) ? 2'd0 : r_prefix_progress;
        idx_inc           = {1'b0, r_event_index} + (ADDR_W+1)'(1);

        if (i_step.clr_event) begin
            n_capturing   = 1'b0;
            n_event_index = '0;
            n_event_flag  = 1'b0;
            n_event_lines = '0;
        end else if (i_step.chr) begin
            if (r_capturing) begin
                o_res.event_write = 1'b1;
                o_res.event_addr  = r_event_index;
                if (32'(idx_inc) >= BUF_LEN - 1) begin
                    n_event_index = '0;
                end else begin
                    n_event_index = idx_inc[ADDR_W-1:0];
                end
                if (i_step.c == CHAR_NEWLINE) begin
                    n_capturing           = 1'b0;
                    n_event_flag          = 1'b1;
                    n_event_lines         = r_event_lines + 8'd1;
                    o_res.event_line_done = 1'b1;
                end
            end else if (i_step.c == prefix_char(prog)) begin
                // A full prefix opens capture and rewinds the cursor; a partial one advances it.
                if (prog == 2'd2) begin
                    n_prefix_progress = 2'd0;
                    n_capturing       = 1'b1;
                end else begin
                    n_prefix_progress = prog + 2'd1;
                end
            end else begin
                n_prefix_progress = 2'd0;
            end
        end

        o_res.event_pending = n_event_flag;
        o_res.event_count   = n_event_lines;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_progress <= '0;
            r_capturing       <= 1'b0;
            r_event_index     <= '0;
            r_event_flag      <= 1'b0;
            r_event_lines     <= '0;
        end else if (i_step.fire) begin
            r_prefix_progress <= n_prefix_progress;
            r_capturing       <= n_capturing;
            r_event_index     <= n_event_index;
            r_event_flag      <= n_event_flag;
            r_event_lines     <= n_event_lines;
        end
    end

endmodule

// ===== design/at_rx_resp.sv =====
// ----------------------------------------------------------------------------
// at_rx_resp: response buffer index and expected-response matcher
// Advances the wrapping response write index and runs the rotating
// single-cursor matcher, which tries every pattern once per character.
// ----------------------------------------------------------------------------
module at_rx_resp import at_rx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_step     i_step,
    output t_resp_res o_res
);

    logic [ADDR_W-1:0] r_resp_index, n_resp_index;
    logic              r_resp_done,  n_resp_done;
    logic [SEL_W-1:0]  r_sel,        n_sel;
    logic [POS_W-1:0]  r_pos,        n_pos;

    logic [7:0]                          len;
    logic [7:0]                          idx_inc;
    logic [NUM_PATTERNS-1:0][SEL_W-1:0]  try_sel;
    logic [NUM_PATTERNS-1:0][POS_W-1:0]  try_pos;
    logic [NUM_PATTERNS-1:0][POS_W-1:0]  try_fin;
    logic [NUM_PATTERNS-1:0]             try_hit;
    logic                                found;

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        if (32'(p) > PATTERN_CHARS - 1) begin
            r = POS_W'(PATTERN_CHARS - 1);
        end else begin
            r = p;
        end
        return r;
    endfunction

    // Candidate selector and position for each attempt; only the first
    // attempt resumes at the stored position, later ones start over.
    always_comb begin
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            if (k == 0) begin
                try_sel[k] = r_sel;
                try_pos[k] = clamp_pos(r_pos);
            end else begin
                try_sel[k] = next_sel(try_sel[k-1]);
                try_pos[k] = '0;
            end
            try_fin[k] = clamp_pos(i_cfg.last_index[POS_W*try_sel[k] +: POS_W]);
            try_hit[k] = (i_step.c == i_cfg.patterns[try_sel[k]][try_pos[k]]);
        end
    end

    always_comb begin
        n_resp_index = r_resp_index;
        n_resp_done  = r_resp_done;
        n_sel        = r_sel;
        n_pos        = r_pos;
        o_res        = '0;
        found        = 1'b0;
        len          = (i_cfg.resp_buffer_len > 8'(BUF_LEN)) ? 8'(BUF_LEN)
                                                             : i_cfg.resp_buffer_len;
        idx_inc      = {1'b0, r_resp_index} + 8'd1;

        if (i_step.clr_resp) begin
            n_resp_done  = 1'b0;
            n_resp_index = '0;
        end else if (i_step.chr && !r_resp_done) begin
            o_res.resp_write = 1'b1;
            o_res.resp_addr  = r_resp_index;
            if (len < 8'd2 || idx_inc >= len - 8'd1) begin
                n_resp_index = '0;
            end else begin
                n_resp_index = idx_inc[ADDR_W-1:0];
            end

            // No hit at all leaves the selector back where it began.
            n_pos = '0;
            n_sel = next_sel(try_sel[NUM_PATTERNS-1]);
            for (int k = 0; k < NUM_PATTERNS; k++) begin
                if (!found && try_hit[k]) begin
                    found = 1'b1;
                    if (try_pos[k] >= try_fin[k]) begin
                        n_resp_done           = 1'b1;
                        n_resp_index          = '0;
                        n_sel                 = '0;
                        n_pos                 = '0;
                        o_res.matched_now     = 1'b1;
                        o_res.matched_pattern = try_sel[k];
                    end else begin
                        n_sel = try_sel[k];
                        n_pos = try_pos[k] + POS_W'(1);
                    end
                end
            end
        end

        o_res.resp_ready = n_resp_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_index <= '0;
            r_resp_done  <= 1'b0;
            r_sel        <= '0;
            r_pos        <= '0;
        end else if (i_step.fire) begin
            r_resp_index <= n_resp_index;
            r_resp_done  <= n_resp_done;
            r_sel        <= n_sel;
            r_pos        <= n_pos;
        end
    end

endmodule
